### design/smt_pkg.sv
// Servo move tracker package: shared types and constants.
// Used by every module of the tracker; no dependencies.
package smt_pkg;

  localparam int POS_W  = 10;
  localparam int TIME_W = 16;
  localparam int NOW_W  = 32;
  localparam int DIVA_W = 27;
  localparam int DIVB_W = 17;

  localparam logic [POS_W-1:0] POS_MAX    = 10'd1000;
  localparam logic [8:0]       DIST_SPAN  = 9'd500;
  localparam logic [POS_W-1:0] POS_RESET  = 10'd500;

  // ceil(2^35 / DIST_SPAN); exact quotient for dividends below 2^26
  localparam logic [26:0]      SPAN_RECIP = 27'd68719477;
  localparam int               SPAN_SHIFT = 35;

  typedef enum logic [1:0] {
    CMD_SMOOTH   = 2'd0,
    CMD_DIRECT   = 2'd1,
    CMD_RECENTER = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SENT    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_BAD_ID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_MIN_TIME = 2'd1,
    REG_MAX_TIME = 2'd2,
    REG_CENTER   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] tgt;
    logic [NOW_W-1:0] start;
    logic             moving;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{cur: POS_RESET, tgt: POS_RESET, start: '0, moving: 1'b0};

  typedef struct packed {
    logic              done;
    logic [DIVA_W-1:0] quo;
    logic              rem_nz;
  } div_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SM_RD,
    S_SM_EV,
    S_MT_MUL,
    S_MT_WAIT,
    S_EMIT,
    S_RC_RD,
    S_RC_ACC,
    S_RC_EMIT,
    S_TK_RD,
    S_TK_EV,
    S_TK_EST,
    S_TK_DIV,
    S_TK_NEXT
  } state_t;

endpackage

### design/smt_mem.sv
// Servo state memory: one write port, one registered read port.
// Per-entry valid bits give the reset entry until written. Uses smt_pkg.
module smt_mem
  import smt_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t            mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  entry_t            q;
  logic              q_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      q_ok <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      q_ok <= vld[raddr];
    end
  end

  assign rdata = q_ok ? q : ENTRY_RESET;

endmodule

### design/smt_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Unsigned dividend and divisor; reports quotient and nonzero remainder. Uses smt_pkg.
module smt_div
  import smt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVA_W-1:0] a,
  input  logic [DIVB_W-1:0] b,
  output div_res_t          res
);

  logic [DIVA_W-1:0] quo;
  logic [DIVB_W-1:0] rem;
  logic [DIVB_W-1:0] dvs;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;
  logic [DIVB_W:0]   shifted;
  logic [DIVB_W:0]   trial;

  assign shifted = {rem, quo[DIVA_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= a;
      rem <= '0;
      dvs <= b;
    end else if (busy) begin
      if (!trial[DIVB_W]) begin
        rem <= trial[DIVB_W-1:0];
        quo <= {quo[DIVA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVB_W-1:0];
        quo <= {quo[DIVA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIVA_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res = '{done: done, quo: quo, rem_nz: (rem != '0)};

endmodule

### design/servo_move_tracker_core.sv
// Servo move tracker: top level with the command sequencer.
// Uses smt_pkg, smt_mem (servo state) and smt_div (tick estimate divider).
//
// in_valid/in_stall takes one command word: smooth move, direct move,
// recenter all, or time tick. out_valid/out_stall carries result words; a
// smooth or direct move gives one word, recenter one word per servo with last
// set on the final one, a tick none. cfg_we/cfg_idx/cfg_data write the
// configuration registers; the user must do so only while no command is in
// flight, which the block does not enforce. One command at a time: in_stall
// is high from the accepting edge until the sequencer is idle again. Direct
// moves go straight to emit; smooth ones emit after the read on a bad id,
// after evaluation in the deadzone, else after a reciprocal multiply for
// the move time. Recenter reads each entry in turn, scales once, then writes
// one entry per delivered word. A tick may run the 27-step divider for each
// moving servo. A word waits in the output register while out_stall is high
// and the sequencer holds until that register frees. Reset restores the
// register defaults and marks every servo entry as centered and at rest.
module servo_move_tracker_core
  import smt_pkg::*;
#(
  parameter int SERVO_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [7:0]          servo_id,
  input  logic signed [15:0]  position,
  input  logic [TIME_W-1:0]   move_time_in,
  input  logic [NOW_W-1:0]    now_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [7:0]          servo_out,
  output logic [POS_W-1:0]    position_out,
  output logic [TIME_W-1:0]   move_time_out,
  output logic                last,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [TIME_W-1:0]   cfg_data
);

  localparam int IW = $clog2(SERVO_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(SERVO_COUNT - 1);

  state_t state, state_next;

  logic [POS_W-1:0]  deadzone, center_cfg;
  logic [TIME_W-1:0] t_min, t_max;

  cmd_t              cmd_r;
  logic [7:0]        id_r;
  logic [POS_W-1:0]  pos_r;
  logic [NOW_W-1:0]  now_r;
  logic [IW-1:0]     idx;
  entry_t            ent;
  logic [POS_W:0]    far;
  logic [TIME_W-1:0] t_r;
  logic              mt_neg;
  logic              tk_neg;

  status_t           p_status;
  logic [TIME_W-1:0] p_time;
  logic              p_we;
  entry_t            p_wdata;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [IW-1:0]     mem_raddr;
  entry_t            mem_rdata;

  logic              div_start;
  logic [DIVA_W-1:0] div_a;
  logic [DIVB_W-1:0] div_b;
  div_res_t          div_res;

  logic              slot_free;
  logic              out_load;
  logic              accept;

  // input decode
  logic              id_ok;
  logic [POS_W-1:0]  pos_in_c;
  logic [POS_W-1:0]  cent_c;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign id_ok     = (id_r >= 8'd1) && (id_r <= 8'(SERVO_COUNT));
  assign pos_in_c  = position[15] ? '0 :
                     (position > $signed({6'd0, POS_MAX})) ? POS_MAX : position[POS_W-1:0];
  assign cent_c    = (center_cfg > POS_MAX) ? POS_MAX : center_cfg;

  // move-time arithmetic
  logic signed [17:0] span;
  logic [POS_W:0]     mt_dist;
  logic signed [29:0] mt_prod;
  logic [25:0]        mt_mag;
  logic [25:0]        mag_r;
  logic [52:0]        mt_full;
  logic [17:0]        mt_quo_r;
  logic signed [19:0] mt_q;
  logic signed [19:0] t_sum;
  logic [TIME_W-1:0]  t_c;

  // per-entry arithmetic
  logic [POS_W:0]     dist_sm;
  logic [POS_W:0]     dist_rc;
  logic [POS_W:0]     far_next;
  logic signed [11:0] diff;
  logic [POS_W:0]     abs_diff;
  logic [NOW_W-1:0]   elapsed;
  logic [POS_W:0]     ad_r;
  logic [DIVA_W-1:0]  tk_num;
  logic [11:0]        qmag;
  logic signed [12:0] qs;
  logic signed [12:0] newp;
  logic [POS_W-1:0]   newp_c;

  assign span    = $signed({2'b0, t_max}) - $signed({2'b0, t_min});
  assign mt_prod = $signed({1'b0, mt_dist}) * span;
  assign mt_mag  = mt_prod[29] ? 26'(-mt_prod) : 26'(mt_prod);
  assign mt_full = {27'd0, mag_r} * {26'd0, SPAN_RECIP};
  assign mt_q    = mt_neg ? -$signed({2'b0, mt_quo_r}) : $signed({2'b0, mt_quo_r});
  assign t_sum   = $signed({4'b0, t_min}) + mt_q;
  assign t_c     = (t_sum < $signed({4'b0, t_min})) ? t_min :
                   (t_sum > $signed({4'b0, t_max})) ? t_max :
                   t_sum[TIME_W-1:0];

  assign dist_sm  = (pos_r >= mem_rdata.cur) ? {1'b0, pos_r - mem_rdata.cur}
                                             : {1'b0, mem_rdata.cur - pos_r};
  assign dist_rc  = (cent_c >= mem_rdata.cur) ? {1'b0, cent_c - mem_rdata.cur}
                                              : {1'b0, mem_rdata.cur - cent_c};
  assign far_next = (dist_rc > far) ? dist_rc : far;
  assign diff     = $signed({2'b0, mem_rdata.tgt}) - $signed({2'b0, mem_rdata.cur});
  assign abs_diff = diff[11] ? 11'(-diff) : 11'(diff);
  assign elapsed  = now_r - ent.start;
  // |target - current| times elapsed for the estimate divide
  assign tk_num   = {16'd0, ad_r} * {11'd0, elapsed[15:0]};
  assign qmag     = {1'b0, div_res.quo[POS_W:0]} + {11'd0, div_res.rem_nz & tk_neg};
  assign qs       = tk_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign newp     = $signed({3'b0, ent.cur}) + qs;
  assign newp_c   = newp[12] ? '0 :
                    (newp > $signed({3'b0, POS_MAX})) ? POS_MAX : newp[POS_W-1:0];

  always_comb begin
    case (state)
      S_SM_EV:  mt_dist = dist_sm;
      S_RC_ACC: mt_dist = far_next;
      default:  mt_dist = abs_diff;
    endcase
  end

  smt_mem #(.DEPTH(SERVO_COUNT), .AW(IW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .res   (div_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(cmd))
            CMD_SMOOTH:   state_next = S_SM_RD;
            CMD_DIRECT:   state_next = S_EMIT;
            CMD_RECENTER: state_next = S_RC_RD;
            default:      state_next = S_TK_RD;
          endcase
        end
      end
      S_SM_RD:   state_next = id_ok ? S_SM_EV : S_EMIT;
      S_SM_EV:   state_next = (dist_sm <= {1'b0, deadzone}) ? S_EMIT : S_MT_MUL;
      S_MT_MUL:  state_next = S_MT_WAIT;
      S_MT_WAIT: begin
        case (cmd_r)
          CMD_SMOOTH:   state_next = S_EMIT;
          CMD_RECENTER: state_next = S_RC_EMIT;
          default:      state_next = S_TK_EST;
        endcase
      end
      S_EMIT:    state_next = slot_free ? S_IDLE : S_EMIT;
      S_RC_RD:   state_next = S_RC_ACC;
      S_RC_ACC:  state_next = (idx == LAST_IDX) ? S_MT_MUL : S_RC_RD;
      S_RC_EMIT: state_next = (slot_free && idx == LAST_IDX) ? S_IDLE : S_RC_EMIT;
      S_TK_RD:   state_next = S_TK_EV;
      S_TK_EV:   state_next = mem_rdata.moving ? S_MT_MUL : S_TK_NEXT;
      S_TK_EST: begin
        if (elapsed >= {16'd0, t_r}) state_next = S_TK_NEXT;
        else if (elapsed != '0 && t_r != '0) state_next = S_TK_DIV;
        else state_next = S_TK_NEXT;
      end
      S_TK_DIV:  state_next = div_res.done ? S_TK_NEXT : S_TK_DIV;
      S_TK_NEXT: state_next = (idx == LAST_IDX) ? S_IDLE : S_TK_RD;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = p_wdata;
    mem_raddr = idx;
    div_start = 1'b0;
    div_a     = tk_num;
    div_b     = {1'b0, t_r};
    out_load  = 1'b0;
    case (state)
      S_EMIT: begin
        out_load = slot_free;
        mem_we   = slot_free && p_we;
      end
      S_RC_EMIT: begin
        out_load  = slot_free;
        mem_we    = slot_free;
        mem_wdata = '{cur: cent_c, tgt: cent_c, start: now_r, moving: 1'b0};
      end
      S_TK_EST: begin
        if (elapsed >= {16'd0, t_r}) begin
          mem_we    = 1'b1;
          mem_wdata = '{cur: ent.tgt, tgt: ent.tgt, start: ent.start, moving: 1'b0};
        end else begin
          div_start = (elapsed != '0) && (t_r != '0);
        end
      end
      S_TK_DIV: begin
        mem_we    = div_res.done;
        mem_wdata = '{cur: newp_c, tgt: ent.tgt, start: ent.start, moving: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      deadzone      <= 10'd5;
      t_min         <= 16'd100;
      t_max         <= 16'd1000;
      center_cfg    <= POS_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_DEADZONE: deadzone   <= cfg_data[POS_W-1:0];
          REG_MIN_TIME: t_min      <= cfg_data;
          REG_MAX_TIME: t_max      <= cfg_data;
          REG_CENTER:   center_cfg <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // move time: magnitude, then reciprocal of the distance span
  always_ff @(posedge clk) begin
    mag_r    <= mt_mag;
    mt_quo_r <= mt_full[SPAN_SHIFT+17:SPAN_SHIFT];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_RC_EMIT) begin
        status        <= ST_SENT;
        servo_out     <= 8'(idx) + 8'd1;
        position_out  <= cent_c;
        move_time_out <= t_r;
        last          <= (idx == LAST_IDX);
      end else begin
        status        <= p_status;
        servo_out     <= id_r;
        position_out  <= pos_r;
        move_time_out <= p_time;
        last          <= 1'b1;
      end
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r    <= cmd_t'(cmd);
          id_r     <= servo_id;
          pos_r    <= pos_in_c;
          now_r    <= now_ms;
          far      <= '0;
          p_status <= ST_BAD_ID;
          p_time   <= '0;
          p_we     <= 1'b0;
          idx      <= (cmd_t'(cmd) == CMD_SMOOTH || cmd_t'(cmd) == CMD_DIRECT)
                      ? IW'(servo_id - 8'd1) : '0;
          if (cmd_t'(cmd) == CMD_DIRECT &&
              servo_id >= 8'd1 && servo_id <= 8'(SERVO_COUNT)) begin
            p_status <= ST_SENT;
            p_time   <= move_time_in;
            p_we     <= 1'b1;
            p_wdata  <= '{cur: pos_in_c, tgt: pos_in_c, start: now_ms, moving: 1'b0};
          end
        end
      end
      S_SM_RD: ;
      S_SM_EV: begin
        ent    <= mem_rdata;
        mt_neg <= span[17];
        if (dist_sm <= {1'b0, deadzone}) p_status <= ST_IGNORED;
      end
      S_MT_WAIT: begin
        t_r <= t_c;
        if (cmd_r == CMD_SMOOTH) begin
          p_status <= ST_SENT;
          p_time   <= t_c;
          p_we     <= 1'b1;
          p_wdata  <= '{cur: ent.cur, tgt: pos_r, start: now_r, moving: 1'b1};
        end
        if (cmd_r == CMD_RECENTER) idx <= '0;
      end
      S_RC_ACC: begin
        far    <= far_next;
        mt_neg <= span[17];
        if (idx != LAST_IDX) idx <= idx + IW'(1);
      end
      S_RC_EMIT: begin
        if (slot_free && idx != LAST_IDX) idx <= idx + IW'(1);
      end
      S_TK_EV: begin
        ent    <= mem_rdata;
        ad_r   <= abs_diff;
        tk_neg <= diff[11];
        mt_neg <= span[17];
      end
      S_TK_NEXT: begin
        if (idx != LAST_IDX) idx <= idx + IW'(1);
      end
      default: ;
    endcase
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_TK_DIV))
    else $error("divider finished outside the estimate state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> slot_free)
    else $error("output register overwritten");

  a_rc_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && state == S_RC_EMIT && idx == LAST_IDX) |=> (state == S_IDLE))
    else $error("recenter did not finish after last word");

endmodule
